>>> rtl/mbd_pkg.sv
// Shared types and constants for the multi-button debouncer.
package mbd_pkg;

	localparam int MAX_BUTTONS_DEF = 8;
	localparam int TIME_BITS_DEF   = 40;

	localparam int ID_W     = 8;
	localparam int NOW_W    = 40;
	localparam int DEB_W    = 16;
	localparam int COUNT_W  = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W    = 64;
	localparam int S_DATA_W = 56;
	localparam int M_DATA_W = 16;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_BACKWARDS = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BUTTON_COUNT  = 3'd0,
		CFG_BUTTON_IDS    = 3'd1,
		CFG_ACTIVE_LEVELS = 3'd2,
		CFG_DEB_LOW       = 3'd3,
		CFG_DEB_HIGH      = 3'd4
	} cfg_index_t;

	// Per-item table lookup result that follows the item down the pipeline.
	typedef struct packed {
		logic             found;
		logic             active;
		logic [DEB_W-1:0] debounce;
	} lkp_t;

endpackage

>>> rtl/mbd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module mbd_ram
	#(
		parameter int WIDTH = 8,
		parameter int DEPTH = 8,
		localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
	)
	(
		input  logic             clk,
		input  logic             we,
		input  logic [AW-1:0]    waddr,
		input  logic [WIDTH-1:0] wdata,
		input  logic             re,
		input  logic [AW-1:0]    raddr,
		output logic [WIDTH-1:0] rdata
	);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; the data register holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/mbd_lookup.sv
// Configuration registers and the parallel id match of the button table.
module mbd_lookup
	import mbd_pkg::*;
	#(
		parameter int MAX_BUTTONS = MAX_BUTTONS_DEF,
		localparam int IDX_W = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1
	)
	(
		input  logic                 clk,
		input  logic                 arst_n,
		input  logic                 cfg_we,
		input  logic [CFG_IDX_W-1:0] cfg_index,
		input  logic [CFG_W-1:0]     cfg_data,
		input  logic [ID_W-1:0]      id,
		output logic [IDX_W-1:0]     idx,
		output lkp_t                 lkp
	);

	logic [COUNT_W-1:0]  count_q;
	logic [CFG_W-1:0]    ids_q;
	logic [7:0]          levels_q;
	logic [2*CFG_W-1:0]  debs_q;
	logic [COUNT_W-1:0]  count_sat;

	// Register writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= COUNT_W'(1);
			ids_q    <= '0;
			levels_q <= '0;
			debs_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BUTTON_COUNT:  count_q  <= cfg_data[COUNT_W-1:0];
				CFG_BUTTON_IDS:    ids_q    <= cfg_data;
				CFG_ACTIVE_LEVELS: levels_q <= cfg_data[7:0];
				CFG_DEB_LOW:       debs_q[CFG_W-1:0] <= cfg_data;
				CFG_DEB_HIGH:      debs_q[2*CFG_W-1:CFG_W] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign count_sat = (count_q > COUNT_W'(MAX_BUTTONS)) ? COUNT_W'(MAX_BUTTONS) : count_q;

	// Compare all entries at once; scanning downward lets the lowest match win.
	always_comb begin
		idx          = '0;
		lkp.found    = 1'b0;
		lkp.active   = 1'b0;
		lkp.debounce = '0;
		for (int k = MAX_BUTTONS - 1; k >= 0; k--) begin
			if ((COUNT_W'(k) < count_sat) && (id != '0) && (ids_q[8*k +: 8] == id)) begin
				idx          = IDX_W'(k);
				lkp.found    = 1'b1;
				lkp.active   = levels_q[k];
				lkp.debounce = debs_q[DEB_W*k +: DEB_W];
			end
		end
	end

endmodule

>>> rtl/mbd_update.sv
// Debounce decision for one entry: next state, reply state and status.
module mbd_update
	import mbd_pkg::*;
	#(
		parameter int TIME_BITS = TIME_BITS_DEF,
		localparam int ST_W = TIME_BITS + 3
	)
	(
		input  lkp_t                 lkp,
		input  logic                 mode,
		input  logic                 pin_level,
		input  logic [TIME_BITS-1:0] now,
		input  logic [ST_W-1:0]      cur,
		output logic [ST_W-1:0]      nxt,
		output logic                 we,
		output logic                 button_state,
		output status_t              status
	);

	logic                 conf, cand, cv, sampled;
	logic [TIME_BITS-1:0] start;
	logic                 n_conf, n_cand, n_cv;
	logic [TIME_BITS-1:0] n_start;
	logic [TIME_BITS-1:0] elapsed;

	assign conf    = cur[0];
	assign cand    = cur[1];
	assign cv      = cur[2];
	assign start   = cur[ST_W-1:3];
	assign sampled = (pin_level == lkp.active);
	assign elapsed = now - start;

	// Entry state layout: start time, candidate valid, candidate, confirmed.
	always_comb begin
		n_conf  = conf;
		n_cand  = cand;
		n_cv    = cv;
		n_start = start;
		status  = ST_OK;
		if (!lkp.found) begin
			status = ST_NOT_FOUND;
		end else if (mode) begin
			n_conf = sampled;
			n_cv   = 1'b0;
		end else if (sampled == conf) begin
			n_cv = 1'b0;
		end else if (!cv || (cand != sampled)) begin
			n_cand  = sampled;
			n_start = now;
			n_cv    = 1'b1;
		end else if (now < start) begin
			status = ST_BACKWARDS;
		end else if (elapsed >= TIME_BITS'(lkp.debounce)) begin
			n_conf = sampled;
			n_cv   = 1'b0;
		end
	end

	assign nxt          = {n_start, n_cv, n_cand, n_conf};
	assign we           = (status == ST_OK);
	assign button_state = (status == ST_OK) ? n_conf : 1'b0;

endmodule

>>> rtl/multi_button_debouncer_top.sv
// Multi-button debouncer top level: lookup, state RAM pipeline and output register.
//
// In the first stage the button id is matched against all table entries in
// parallel and the entry's state is read from a RAM with a registered read
// port; in the second stage the state is updated and written back, and the
// reply is loaded into the output register. Back-to-back beats for the same
// button are forwarded from the write-back, so the sustained rate is one beat
// per cycle whenever the output side takes replies. Per-entry valid flops make
// the state read as zero after reset without a clearing pass. Configuration
// must be written only while idle; the block itself does not enforce this.
module multi_button_debouncer_top
	import mbd_pkg::*;
	#(
		parameter int MAX_BUTTONS = MAX_BUTTONS_DEF,
		parameter int TIME_BITS   = TIME_BITS_DEF
	)
	(
		input  logic                 clk,
		input  logic                 arst_n,
		input  logic                 s_tvalid,
		output logic                 s_tready,
		// button_id [7:0], pin_level [8], now_ms [48:9], zero fill above
		input  logic [S_DATA_W-1:0]  s_tdata,
		// mode [0]
		input  logic                 s_tuser,
		output logic                 m_tvalid,
		input  logic                 m_tready,
		// reply_id [7:0], button_state [8], status [10:9], zero fill above
		output logic [M_DATA_W-1:0]  m_tdata,
		input  logic                 cfg_we,
		input  logic [CFG_IDX_W-1:0] cfg_index,
		input  logic [CFG_W-1:0]     cfg_data
	);

	localparam int IDX_W = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;
	localparam int ST_W  = TIME_BITS + 3;

	logic                 s_accept;
	logic [TIME_BITS-1:0] now_in;
	logic [IDX_W-1:0]     idx;
	lkp_t                 lkp;

	logic                 s1_valid_q;
	logic                 s1_go;
	logic [IDX_W-1:0]     idx_s1;
	lkp_t                 lkp_s1;
	logic                 mode_s1;
	logic                 raw_s1;
	logic [ID_W-1:0]      id_s1;
	logic [TIME_BITS-1:0] now_s1;
	logic                 fwd_s1;
	logic [ST_W-1:0]      fwd_data_s1;

	logic [ST_W-1:0]        ram_rdata;
	logic [ST_W-1:0]        cur;
	logic [ST_W-1:0]        nxt;
	logic                   upd_we;
	logic                   ram_we;
	logic                   upd_state;
	status_t                upd_status;
	logic [MAX_BUTTONS-1:0] ent_valid_q;

	logic                 m_tvalid_q;
	logic [M_DATA_W-1:0]  m_tdata_q;

	// Bring the time field to the configured width.
	for (genvar i = 0; i < TIME_BITS; i++) begin : g_now
		if (i < NOW_W) begin : g_bit
			assign now_in[i] = s_tdata[9 + i];
		end else begin : g_zero
			assign now_in[i] = 1'b0;
		end
	end

	// Handshake: the second stage moves when the output register is free or drained.
	assign s1_go    = s1_valid_q && (!m_tvalid_q || m_tready);
	assign s_tready = !s1_valid_q || s1_go;
	assign s_accept = s_tvalid && s_tready;
	assign ram_we   = s1_go && upd_we;

	mbd_lookup #(.MAX_BUTTONS(MAX_BUTTONS)) u_lookup (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.id        (s_tdata[ID_W-1:0]),
		.idx       (idx),
		.lkp       (lkp)
	);

	mbd_ram #(.WIDTH(ST_W), .DEPTH(MAX_BUTTONS)) u_state_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_s1),
		.wdata (nxt),
		.re    (s_accept),
		.raddr (idx),
		.rdata (ram_rdata)
	);

	// Second-stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	// Second-stage payload, with a bypass when the entry is being written back.
	always_ff @(posedge clk) begin
		if (s_accept) begin
			idx_s1      <= idx;
			lkp_s1      <= lkp;
			mode_s1     <= s_tuser;
			raw_s1      <= s_tdata[8];
			id_s1       <= s_tdata[ID_W-1:0];
			now_s1      <= now_in;
			fwd_s1      <= ram_we && (idx_s1 == idx);
			fwd_data_s1 <= nxt;
		end
	end

	// An entry never written since reset reads as all zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_valid_q <= '0;
		end else if (ram_we) begin
			ent_valid_q[idx_s1] <= 1'b1;
		end
	end

	always_comb begin
		if (fwd_s1) begin
			cur = fwd_data_s1;
		end else if (ent_valid_q[idx_s1]) begin
			cur = ram_rdata;
		end else begin
			cur = '0;
		end
	end

	mbd_update #(.TIME_BITS(TIME_BITS)) u_update (
		.lkp          (lkp_s1),
		.mode         (mode_s1),
		.pin_level    (raw_s1),
		.now          (now_s1),
		.cur          (cur),
		.nxt          (nxt),
		.we           (upd_we),
		.button_state (upd_state),
		.status       (upd_status)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s1_go) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			m_tdata_q <= {5'b0, upd_status, upd_state,
				(upd_status == ST_OK) ? id_s1 : {ID_W{1'b0}}};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// A stalled second stage must not take a new beat.
	a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_go) |-> !s_accept)
		else $error("beat accepted while second stage stalled");

	// State is written back only as the second stage moves on.
	a_we_with_advance: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (s1_valid_q && m_tready) || (s1_valid_q && !m_tvalid_q))
		else $error("state write without stage advance");

	// A bypass flagged as a beat enters an empty second stage follows a write-back.
	a_fwd_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(s1_valid_q) && fwd_s1 |-> $past(ram_we))
		else $error("bypass flagged without a write-back");

	// Error replies carry neither an id nor a pressed state.
	a_error_reply_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[10:9] != ST_OK)) |-> (m_tdata[8:0] == 9'd0))
		else $error("error reply with nonzero id or state");

endmodule

>>> sim/mbd_tracker_pkg.sv
// Button-state tracker class that predicts and checks the debouncer's reply beats.
package mbd_tracker_pkg;
	import mbd_pkg::*;

	// One predicted reply beat.
	typedef struct {
		logic [ID_W-1:0] id;
		logic            pressed;
		status_t         status;
	} reply_t;

	class button_state_tracker;
		logic [COUNT_W-1:0] button_count;
		logic [CFG_W-1:0]   button_ids;
		logic [7:0]         active_levels;
		logic [CFG_W-1:0]   deb_low;
		logic [CFG_W-1:0]   deb_high;

		bit                 confirmed   [MAX_BUTTONS_DEF];
		bit                 candidate   [MAX_BUTTONS_DEF];
		bit                 cand_valid  [MAX_BUTTONS_DEF];
		logic [NOW_W-1:0]   cand_start  [MAX_BUTTONS_DEF];

		reply_t             pending_replies [$];

		int errors;
		int n_ok;
		int n_not_found;
		int n_backwards;
		int n_confirms;
		int n_settings;

		function new();
			int k;
			button_count  = 1;
			button_ids    = '0;
			active_levels = '0;
			deb_low       = '0;
			deb_high      = '0;
			for (k = 0; k < MAX_BUTTONS_DEF; k++) begin
				confirmed[k]  = 0;
				candidate[k]  = 0;
				cand_valid[k] = 0;
				cand_start[k] = '0;
			end
			errors      = 0;
			n_ok        = 0;
			n_not_found = 0;
			n_backwards = 0;
			n_confirms  = 0;
			n_settings  = 0;
		endfunction

		// Mirror a register write; narrow registers keep only their low bits.
		function void write_reg(cfg_index_t idx, logic [CFG_W-1:0] value);
			case (idx)
				CFG_BUTTON_COUNT:  button_count  = value[COUNT_W-1:0];
				CFG_BUTTON_IDS:    button_ids    = value;
				CFG_ACTIVE_LEVELS: active_levels = value[7:0];
				CFG_DEB_LOW:       deb_low       = value;
				CFG_DEB_HIGH:      deb_high      = value;
				default: ;
			endcase
		endfunction

		// Lowest in-use entry holding the id, or -1; id zero never matches.
		function int find_entry(logic [ID_W-1:0] id);
			int used;
			int k;
			used = (button_count > MAX_BUTTONS_DEF) ? MAX_BUTTONS_DEF : int'(button_count);
			if (id == 0)
				return -1;
			for (k = 0; k < used; k++) begin
				if (button_ids[8*k +: 8] == id)
					return k;
			end
			return -1;
		endfunction

		function logic [DEB_W-1:0] deb_time(int k);
			if (k < 4)
				return deb_low[16*k +: 16];
			return deb_high[16*(k-4) +: 16];
		endfunction

		// Update the button table for an accepted beat and queue its reply.
		function void take_reading(bit mode, logic [ID_W-1:0] id, bit level,
			logic [NOW_W-1:0] now);
			reply_t r;
			int     k;
			bit     sampled;
			r.id      = '0;
			r.pressed = 0;
			r.status  = ST_NOT_FOUND;
			k = find_entry(id);
			if (k >= 0) begin
				sampled  = (level == active_levels[k]);
				r.status = ST_OK;
				if (mode) begin
					confirmed[k]  = sampled;
					cand_valid[k] = 0;
				end else if (sampled == confirmed[k]) begin
					cand_valid[k] = 0;
				end else if (!cand_valid[k] || candidate[k] != sampled) begin
					candidate[k]  = sampled;
					cand_start[k] = now;
					cand_valid[k] = 1;
				end else if (now < cand_start[k]) begin
					r.status = ST_BACKWARDS;
				end else if (now - cand_start[k] >= {24'd0, deb_time(k)}) begin
					confirmed[k]  = sampled;
					cand_valid[k] = 0;
					n_confirms++;
				end
				if (r.status == ST_OK) begin
					r.id      = id;
					r.pressed = confirmed[k];
				end
			end
			case (r.status)
				ST_OK:        n_ok++;
				ST_NOT_FOUND: n_not_found++;
				default:      n_backwards++;
			endcase
			pending_replies.push_back(r);
		endfunction

		// Compare one reply beat with the oldest predicted reply.
		function void compare_reply(logic [M_DATA_W-1:0] beat);
			reply_t r;
			if (pending_replies.size() == 0) begin
				$error("reply beat %h arrived with no reading outstanding", beat);
				errors++;
				return;
			end
			r = pending_replies.pop_front();
			if (beat[7:0] !== r.id) begin
				$error("reply_id: expected %0d, actual %0d", r.id, beat[7:0]);
				errors++;
			end
			if (beat[8] !== r.pressed) begin
				$error("button_state: expected %0d, actual %0d", r.pressed, beat[8]);
				errors++;
			end
			if (beat[10:9] !== r.status) begin
				$error("status: expected %0d, actual %0d", r.status, beat[10:9]);
				errors++;
			end
			if (beat[15:11] !== 5'd0) begin
				$error("zero fill: expected 0, actual %0d", beat[15:11]);
				errors++;
			end
		endfunction

		function int outstanding();
			return pending_replies.size();
		endfunction
	endclass

endpackage

>>> sim/tb.sv
// Testbench top for the multi-button debouncer: directed and random readings with idling.
module tb;
	import mbd_pkg::*;
	import mbd_tracker_pkg::*;

	logic                 clk       = 0;
	logic                 arst_n    = 0;
	logic                 s_tvalid  = 0;
	logic [S_DATA_W-1:0]  s_tdata   = '0;
	logic                 s_tuser   = 0;
	logic                 m_tready  = 0;
	logic                 cfg_we    = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;
	logic                 s_tready;
	logic                 m_tvalid;
	logic [M_DATA_W-1:0]  m_tdata;

	button_state_tracker tracker;

	bit               tx_idle;
	bit               rx_idle;
	int               rx_wait;
	logic [NOW_W-1:0] clock_ms;
	bit               held_level [MAX_BUTTONS_DEF];

	multi_button_debouncer_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// Reply side: check each accepted beat, then stall at random when reply idling is on.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 0;
			rx_wait = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				tracker.compare_reply(m_tdata);
				rx_wait = rx_idle ? $urandom_range(0, 6) : 0;
			end else if (rx_wait > 0) begin
				rx_wait--;
			end
			m_tready <= (rx_wait == 0);
		end
	end

	// Write one register; the enable stays high so writes can run back to back.
	task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] value);
		cfg_we    <= 1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		tracker.write_reg(idx, value);
	endtask

	task automatic configure(logic [CFG_W-1:0] count, logic [CFG_W-1:0] ids,
		logic [CFG_W-1:0] levels, logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi);
		write_reg(CFG_BUTTON_COUNT, count);
		write_reg(CFG_BUTTON_IDS, ids);
		write_reg(CFG_ACTIVE_LEVELS, levels);
		write_reg(CFG_DEB_LOW, lo);
		write_reg(CFG_DEB_HIGH, hi);
		cfg_we <= 0;
		tracker.n_settings++;
	endtask

	// Present one reading, after a random gap when send idling is on, and hold it until it is taken.
	task automatic send_reading(bit mode, logic [ID_W-1:0] id, bit level,
		logic [NOW_W-1:0] now);
		int gap;
		gap = tx_idle ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser  <= mode;
		s_tdata  <= {7'd0, now, level, id};
		do @(posedge clk); while (!s_tready);
		tracker.take_reading(mode, id, level, now);
	endtask

	// Stop sending and wait until every reply is back.
	task automatic settle();
		s_tvalid <= 0;
		while (tracker.outstanding() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// Mostly held levels with a rising shared time, mixed with bounces,
	// priming, stray ids and time steps backwards.
	task automatic run_phase(int items);
		int               n;
		int               k;
		int               used;
		int               kind;
		logic [ID_W-1:0]  id;
		bit               level;
		bit               mode;
		logic [NOW_W-1:0] now;
		used = (tracker.button_count > MAX_BUTTONS_DEF) ? MAX_BUTTONS_DEF
			: int'(tracker.button_count);
		for (n = 0; n < items; n++) begin
			kind  = $urandom_range(0, 99);
			k     = (used == 0) ? $urandom_range(0, 7) : $urandom_range(0, used - 1);
			id    = tracker.button_ids[8*k +: 8];
			mode  = 0;
			level = held_level[k];
			now   = clock_ms;
			if (kind < 5) begin
				mode  = 1;
				level = 1'($urandom_range(0, 1));
			end else if (kind < 10) begin
				id = ID_W'($urandom_range(0, 255));
			end else if (kind < 12) begin
				id = '0;
			end else if (kind < 15) begin
				now = (clock_ms > 40) ? clock_ms - NOW_W'($urandom_range(1, 40)) : '0;
			end else begin
				if ($urandom_range(0, 3) == 0) begin
					level = 1'($urandom_range(0, 1));
				end else if ($urandom_range(0, 15) == 0) begin
					held_level[k] = ~held_level[k];
					level = held_level[k];
				end
				if ($urandom_range(0, 39) == 0)
					clock_ms += NOW_W'($urandom_range(0, 70000));
				else
					clock_ms += NOW_W'($urandom_range(0, 6));
				now = clock_ms;
			end
			send_reading(mode, id, level, now);
		end
	endtask

	function automatic logic [DEB_W-1:0] pick_debounce();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return 16'hFFFF;
		if (r == 2)
			return DEB_W'($urandom_range(0, 65535));
		return DEB_W'($urandom_range(1, 30));
	endfunction

	initial begin
		int               p;
		int               k;
		int               j;
		logic [CFG_W-1:0] count;
		logic [CFG_W-1:0] ids;
		logic [CFG_W-1:0] levels;
		logic [CFG_W-1:0] lo;
		logic [CFG_W-1:0] hi;
		logic [NOW_W-1:0] base;

		tracker = new();
		tx_idle = 1;
		rx_idle = 1;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Three entries in use, a duplicate id, one id past the count, mixed levels.
		configure(64'd3, 64'h0000_0000_80FF_01FF, 64'h02, 64'h0001_FFFF_000A_0000, 64'd0);
		send_reading(0, 8'h00, 0, 40'd0);
		send_reading(0, 8'h80, 1, 40'd0);
		send_reading(1, 8'hFF, 1, 40'd0);
		send_reading(0, 8'hFF, 0, 40'd0);
		send_reading(0, 8'hFF, 0, 40'd0);
		send_reading(0, 8'h01, 1, 40'd100);
		send_reading(0, 8'h01, 1, 40'd99);
		send_reading(0, 8'h01, 0, 40'd105);
		send_reading(0, 8'h01, 1, 40'd106);
		send_reading(0, 8'h01, 1, 40'd115);
		send_reading(0, 8'h01, 1, 40'd116);
		send_reading(1, 8'h01, 0, 40'd120);
		send_reading(0, 8'hFF, 1, 40'hFF_FFFF_FFFF);
		send_reading(0, 8'hFF, 1, 40'hFF_FFFF_FFFF);
		send_reading(1, 8'h01, 1, 40'hFF_FFFF_FFFF);
		settle();

		// No entries in use.
		configure(64'd0, 64'h0000_0000_80FF_01FF, 64'h02, 64'h0001_FFFF_000A_0000, 64'd0);
		send_reading(0, 8'hFF, 0, 40'd200);
		send_reading(1, 8'h01, 1, 40'd200);
		settle();

		// Count above the table size, an entry holding id zero, longest debounce.
		configure(64'd15, 64'h7766_5544_3322_1100, 64'h80, 64'd0,
			64'hFFFF_0000_0000_0000);
		send_reading(0, 8'h77, 0, 40'd5);
		send_reading(0, 8'h77, 1, 40'd5);
		send_reading(0, 8'h77, 1, 40'd65539);
		send_reading(0, 8'h77, 1, 40'd65540);
		send_reading(0, 8'h00, 1, 40'd65540);
		send_reading(0, 8'h66, 1, 40'd65541);
		settle();

		// Random phases, each with its own table setting, under varied traffic shapes.
		for (p = 0; p < 8; p++) begin
			case (p)
				0:       count = 64'd8;
				1:       count = 64'd0;
				2:       count = 64'd15;
				3:       count = 64'd1;
				default: count = CFG_W'($urandom_range(1, 15));
			endcase
			count[CFG_W-1:COUNT_W] = (CFG_W-COUNT_W)'({$urandom, $urandom});
			ids = '0;
			for (k = 0; k < MAX_BUTTONS_DEF; k++) begin
				ids[8*k +: 8] = 8'($urandom_range(1, 255));
				if ($urandom_range(0, 7) == 0) begin
					ids[8*k +: 8] = 8'd0;
				end else if (k > 0 && $urandom_range(0, 5) == 0) begin
					j = $urandom_range(0, k - 1);
					ids[8*k +: 8] = ids[8*j +: 8];
				end
			end
			levels = {$urandom, $urandom};
			if (p == 0)
				levels[7:0] = 8'h00;
			else if (p == 1)
				levels[7:0] = 8'hFF;
			for (k = 0; k < 4; k++) begin
				lo[16*k +: 16] = pick_debounce();
				hi[16*k +: 16] = pick_debounce();
			end
			if (p == 3) begin
				lo = '0;
				hi = '0;
			end else if (p == 4) begin
				lo = '1;
				hi = '1;
			end
			configure(count, ids, levels, lo, hi);

			base = {8'($urandom_range(0, 255)), 32'($urandom)};
			if (p == 5 || base > 40'hFF_FFF0_0000)
				base = 40'hFF_FFF0_0000;
			else if (p == 6)
				base = '0;
			clock_ms = base;
			for (k = 0; k < MAX_BUTTONS_DEF; k++)
				held_level[k] = 1'($urandom_range(0, 1));
			tx_idle = (p % 4 != 3) && (p != 6);
			rx_idle = (p % 4 != 2) && (p != 6);
			run_phase(118);
			settle();
		end

		$display("Covered %0d readings over %0d table settings:",
			tracker.n_ok + tracker.n_not_found + tracker.n_backwards, tracker.n_settings);
		$display("  %0d ok, %0d unknown id, %0d time reversals, %0d debounced changes.",
			tracker.n_ok, tracker.n_not_found, tracker.n_backwards, tracker.n_confirms);
		if (tracker.errors == 0 && tracker.outstanding() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#5000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
